### rtl/core/sft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sft_pkg: shared types and constants for the sparse fast transpose
// Field widths, fixed matrix bounds, the entry record held by each cell,
// the per-cycle chain control and the control state encoding.
// ----------------------------------------------------------------------------
package sft_pkg;

  localparam int ROW_W = 4;
  localparam int COL_W = 4;
  localparam int VAL_W = 32;
  localparam int CFG_W = 5;

  // Source matrix bounds; rows or columns at or above these are dropped.
  localparam int MAX_COLUMNS = 16;
  localparam int MAX_ROWS    = 16;

  localparam logic [CFG_W-1:0] COLUMN_COUNT_RST = CFG_W'(16);

  typedef struct packed {
    logic [COL_W-1:0]        col;
    logic [ROW_W-1:0]        row;
    logic signed [VAL_W-1:0] value;
  } entry_t;

  // Chain control broadcast to every cell.
  typedef struct packed {
    logic insert;  // place the new entry at its sorted position
    logic shift;   // move every entry one cell toward the output
  } chain_ctrl_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

endpackage

### rtl/core/sft_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sft_cell: one slot of the sorted insertion chain
// Holds one entry. On insert, entries whose column is above the new one
// move one slot away from the output and the first such slot takes the new
// entry, which keeps equal columns in arrival order. On shift, take the
// entry of the neighbor further from the output.
// ----------------------------------------------------------------------------
module sft_cell (
  input  logic                clk,
  input  logic                rst,
  input  sft_pkg::chain_ctrl_t ctrl,
  input  sft_pkg::entry_t     new_entry,
  input  logic                left_after,
  input  logic                left_valid,
  input  sft_pkg::entry_t     left_entry,
  input  logic                right_valid,
  input  sft_pkg::entry_t     right_entry,
  output logic                after,
  output logic                valid,
  output sft_pkg::entry_t     entry
);
  import sft_pkg::*;

  // This slot lies past the insertion point of the new entry.
  assign after = !valid || (entry.col > new_entry.col);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.insert) begin
      if (after) begin
        valid <= left_after ? left_valid : 1'b1;
      end
    end else if (ctrl.shift) begin
      valid <= right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      if (after) begin
        entry <= left_after ? left_entry : new_entry;
      end
    end else if (ctrl.shift) begin
      entry <= right_entry;
    end
  end

endmodule

### rtl/core/sparse_fast_transpose.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_fast_transpose: transpose of a sparse matrix given as triplets
// Triplets enter an insertion chain kept sorted by source column, stable in
// arrival order; the closing transaction, if the chain holds any entry,
// starts a drain that emits them from the chain head, row and column swapped.
//
//   channel  signals                                    direction
//   in       in_valid/in_ready, has_element, in_row,    into block
//            in_col, in_value, in_last
//   out      out_valid/out_ready, out_row, out_col,     out of block
//            out_value, out_last, set_error
//   cfg      cfg_we, cfg_wdata (column_count)           into block
//
// Each kept input transaction is inserted into the chain in one step.
// Entries drain one per cycle from the head cell while out_ready is high;
// in_ready is low during the drain.
// Synchronous reset empties the chain and sets column_count to 16.
// A stall on out holds the head cell; nothing else moves.
// ----------------------------------------------------------------------------
module sparse_fast_transpose #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              has_element,
  input  logic [sft_pkg::ROW_W-1:0]         in_row,
  input  logic [sft_pkg::COL_W-1:0]         in_col,
  input  logic signed [sft_pkg::VAL_W-1:0]  in_value,
  input  logic                              in_last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sft_pkg::ROW_W-1:0]         out_row,
  output logic [sft_pkg::COL_W-1:0]         out_col,
  output logic signed [sft_pkg::VAL_W-1:0]  out_value,
  output logic                              out_last,
  output logic                              set_error,
  input  logic                              cfg_we,
  input  logic [sft_pkg::CFG_W-1:0]         cfg_wdata
);
  import sft_pkg::*;

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  state_t             state, state_next;
  logic [CFG_W-1:0]   column_count;
  logic [CNT_W-1:0]   count, count_next;
  logic               drop_flag, drop_flag_next;

  chain_ctrl_t        ctrl;
  entry_t             new_entry;
  entry_t             cell_entry [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] cell_valid;
  logic [MAX_ENTRIES-1:0] cell_after;

  logic in_xact, out_xact, elem_ok, keep, head_last;

  assign in_xact  = in_valid && in_ready;
  assign out_xact = out_valid && out_ready;

  assign elem_ok = ({1'b0, in_col} < column_count)
                && (int'(in_col) < MAX_COLUMNS)
                && (int'(in_row) < MAX_ROWS)
                && (count < CNT_W'(MAX_ENTRIES));
  assign keep    = in_xact && has_element && elem_ok;

  assign new_entry = '{col: in_col, row: in_row, value: in_value};

  // --------------------------------------------------------------------------
  // Cell chain
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic   l_after, l_valid, r_valid;
    entry_t l_entry, r_entry;

    if (i == 0) begin : g_head
      assign l_after = 1'b0;
      assign l_valid = 1'b0;
      assign l_entry = new_entry;
    end else begin : g_mid
      assign l_after = cell_after[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_entry = cell_entry[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_entry = new_entry;
    end else begin : g_body
      assign r_valid = cell_valid[i+1];
      assign r_entry = cell_entry[i+1];
    end

    sft_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .new_entry   (new_entry),
      .left_after  (l_after),
      .left_valid  (l_valid),
      .left_entry  (l_entry),
      .right_valid (r_valid),
      .right_entry (r_entry),
      .after       (cell_after[i]),
      .valid       (cell_valid[i]),
      .entry       (cell_entry[i])
    );
  end

  if (MAX_ENTRIES == 1) begin : g_last_one
    assign head_last = 1'b1;
  end else begin : g_last_many
    assign head_last = !cell_valid[1];
  end

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  always_comb begin
    state_next     = state;
    count_next     = count;
    drop_flag_next = drop_flag;
    case (state)
      ST_LOAD: begin
        if (in_xact) begin
          if (keep) begin
            count_next = count + CNT_W'(1);
          end
          if (has_element && !elem_ok) begin
            drop_flag_next = 1'b1;
          end
          if (in_last) begin
            if (count_next != '0) begin
              state_next = ST_DRAIN;
            end else begin
              drop_flag_next = 1'b0;
            end
          end
        end
      end
      ST_DRAIN: begin
        if (out_xact && head_last) begin
          state_next     = ST_LOAD;
          count_next     = '0;
          drop_flag_next = 1'b0;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    ctrl.insert = keep;
    ctrl.shift  = 1'b0;
    case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
      end
      ST_DRAIN: begin
        out_valid  = cell_valid[0];
        ctrl.shift = out_xact;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      count        <= '0;
      drop_flag    <= 1'b0;
      column_count <= COLUMN_COUNT_RST;
    end else begin
      state     <= state_next;
      count     <= count_next;
      drop_flag <= drop_flag_next;
      if (cfg_we) begin
        column_count <= cfg_wdata;
      end
    end
  end

  assign out_row   = cell_entry[0].col;
  assign out_col   = cell_entry[0].row;
  assign out_value = cell_entry[0].value;
  assign out_last  = head_last;
  assign set_error = drop_flag;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_contiguous: assert property (@(posedge clk) disable iff (rst)
    (cell_valid & (cell_valid + MAX_ENTRIES'(1))) == '0)
    else $error("chain holds a gap between occupied cells");

  a_count_match: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOAD |-> $countones(cell_valid) == int'(count))
    else $error("stored count disagrees with occupied cells");

  a_drain_head: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAIN |-> cell_valid[0])
    else $error("drain with an empty head cell");

  a_drain_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_last |=> cell_valid == '0)
    else $error("entries left in chain after final transaction");

endmodule
